/* src/bdn_pkg.sv */
// ----------------------------------------------------------------------------
// bdn_pkg: shared types and constants of the bilinear downscaler
// Beat formats of both channels, configuration register indexes, reset
// values and the operand record handed to the interpolation pipeline.
// ----------------------------------------------------------------------------
package bdn_pkg;

	// line buffer geometry
	localparam int MAX_ROW_PIXELS = 1024;
	localparam int MAX_OUT_SIZE   = 1024;
	localparam int MAX_ROWS       = 4096;
	localparam int ROW_ADDR_W     = $clog2(MAX_ROW_PIXELS);

	// configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 29;

	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_SIZE   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SCALE_STEP    = 2'd3;

	// register reset values
	localparam logic [10:0] SOURCE_WIDTH_RST  = 11'd1024;
	localparam logic [12:0] SOURCE_HEIGHT_RST = 13'd1024;
	localparam logic [10:0] OUTPUT_SIZE_RST   = 11'd192;
	localparam int          SCALE_STEP_RST    = 349525;

	// Q16 source position: half step minus one half, saturating at 2^28-1
	localparam int          POS_W       = 28;
	localparam logic [27:0] POS_MAX     = 28'hFFFFFFF;
	localparam logic [27:0] POS_HALF    = 28'd32768;
	localparam logic [27:0] POS_RST     = 28'((SCALE_STEP_RST / 2) - 32768);

	// normalization: 255 in Q16, and ceil(2^30 / 255) for y / 255
	localparam logic [24:0] NORM_OFFSET = 25'd16711680;
	localparam logic [24:0] NORM_ROUND  = 25'd510;
	localparam logic [22:0] RECIP_255   = 23'd4210753;

	typedef struct packed {
		logic [7:0] pixel;
		logic       frame_start;
	} pix_beat_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic [9:0]         out_col;
		logic [9:0]         out_row;
		logic               frame_end;
	} smp_beat_t;

	// sample position carried alongside the arithmetic
	typedef struct packed {
		logic [9:0] out_col;
		logic [9:0] out_row;
		logic       frame_end;
	} smp_meta_t;

	// four neighbors and Q8 weights of one sample
	typedef struct packed {
		logic [7:0] tl;
		logic [7:0] tr;
		logic [7:0] bl;
		logic [7:0] br;
		logic [7:0] fx;
		logic [7:0] fy;
		smp_meta_t  meta;
	} interp_req_t;

endpackage

/* src/bdn_line_ram.sv */
// ----------------------------------------------------------------------------
// bdn_line_ram: line buffer holding the previous source row
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bdn_line_ram
	import bdn_pkg::*;
(
	input  logic                  clk,
	input  logic                  we,
	input  logic [ROW_ADDR_W-1:0] waddr,
	input  logic [7:0]            wdata,
	input  logic                  re,
	input  logic [ROW_ADDR_W-1:0] raddr,
	output logic [7:0]            rdata
);

	logic [7:0] mem [MAX_ROW_PIXELS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/bdn_interp.sv */
// ----------------------------------------------------------------------------
// bdn_interp: bilinear blend and normalization pipeline
// Four arithmetic stages and an output register. The whole pipe advances
// unless the output register holds a beat that is stalled.
// ----------------------------------------------------------------------------
module bdn_interp
	import bdn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  interp_req_t req,
	output logic        req_ready,
	output logic        smp_valid,
	input  logic        smp_stall,
	output smp_beat_t   smp_data
);

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4, out_valid_q;

	logic [15:0] top_s1, bot_s1;
	logic [7:0]  fy_s1;
	smp_meta_t   meta_s1, meta_s2, meta_s3, meta_s4;
	logic [23:0] v16_s2;
	logic [21:0] y_s3;
	logic        neg_s3, neg_s4;
	logic [14:0] q_s4;
	smp_beat_t   out_q;

	logic [8:0]  wx, wx_inv, wy, wy_inv;
	logic [16:0] top_full, bot_full;
	logic [24:0] v16_full;
	logic [24:0] twice, mag, rnd;
	logic        neg;
	logic [44:0] prod;
	logic [15:0] qmag;

	// pipe moves when the output slot is free or being taken
	assign adv       = !(out_valid_q && smp_stall);
	assign req_ready = adv;
	assign smp_valid = out_valid_q;
	assign smp_data  = out_q;

	// stage 1: horizontal blend of both rows
	always_comb begin
		wx       = {1'b0, req.fx};
		wx_inv   = 9'd256 - wx;
		top_full = {9'd0, req.tl} * {8'd0, wx_inv} + {9'd0, req.tr} * {8'd0, wx};
		bot_full = {9'd0, req.bl} * {8'd0, wx_inv} + {9'd0, req.br} * {8'd0, wx};
	end

	// stage 2: vertical blend, Q16 result
	always_comb begin
		wy       = {1'b0, fy_s1};
		wy_inv   = 9'd256 - wy;
		v16_full = {9'd0, top_s1} * {16'd0, wy_inv} + {9'd0, bot_s1} * {16'd0, wy};
	end

	// stage 3: 2v - 255, magnitude plus half divisor, pre-divide by 4
	always_comb begin
		twice = {v16_s2, 1'b0};
		neg   = twice < NORM_OFFSET;
		mag   = neg ? (NORM_OFFSET - twice) : (twice - NORM_OFFSET);
		rnd   = mag + NORM_ROUND;
	end

	// stage 4: divide by 255 through the reciprocal
	assign prod = {23'd0, y_s3} * {22'd0, RECIP_255};

	// sign applied on the way into the output register
	assign qmag = {1'b0, q_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_s1          <= top_full[15:0];
			bot_s1          <= bot_full[15:0];
			fy_s1           <= req.fy;
			meta_s1         <= req.meta;
			v16_s2          <= v16_full[23:0];
			meta_s2         <= meta_s1;
			y_s3            <= rnd[23:2];
			neg_s3          <= neg;
			meta_s3         <= meta_s2;
			q_s4            <= prod[44:30];
			neg_s4          <= neg_s3;
			meta_s4         <= meta_s3;
			out_q.value     <= $signed(neg_s4 ? (16'd0 - qmag) : qmag);
			out_q.out_col   <= meta_s4.out_col;
			out_q.out_row   <= meta_s4.out_row;
			out_q.frame_end <= meta_s4.frame_end;
		end
	end

endmodule

/* src/bilinear_downscale_normalize.sv */
// ----------------------------------------------------------------------------
// bilinear_downscale_normalize: streaming bilinear downscaler, Q14 output
// Source pixels in raster order; the previous row sits in a line RAM.
// Each output sample is emitted on its bottom-right source pixel.
//
//   channel   dir  handshake             beat
//   cfg       in   cfg_we                cfg_index, cfg_data
//   pix       in   pix_valid / pix_stall pix_data  (pixel, frame_start)
//   smp       out  smp_valid / smp_stall smp_data  (value, col, row, frame_end)
//
// A pixel is read from the line RAM at accept, then updated and written back in the
// update state. A pixel that emits a sample also hands it through the request register
// to the five-register arithmetic pipe; no pixel is accepted in the update state.
// Reset clears counters and valid bits; the line RAM is not cleared and holds
// valid data only where the current frame has written it.
// A stalled smp beat holds the pipe; the next pixel waits while a hand-off is held.
// ----------------------------------------------------------------------------
module bilinear_downscale_normalize
	import bdn_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pix_valid,
	output logic                   pix_stall,
	input  pix_beat_t              pix_data,
	output logic                   smp_valid,
	input  logic                   smp_stall,
	output smp_beat_t              smp_data
);

	typedef struct packed {
		logic [11:0] i0;
		logic [11:0] i1;
		logic [7:0]  wt;
	} pos_split_t;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_UPD  = 1'b1;

	// clamped indices and Q8 weight of one axis
	function automatic pos_split_t split_pos(input logic [POS_W-1:0] p,
			input logic [11:0] dim_m1);
		pos_split_t r;
		logic [11:0] a;
		logic [12:0] a1;
		begin
			a    = p[27:16];
			r.i0 = (a > dim_m1) ? dim_m1 : a;
			a1   = {1'b0, r.i0} + 13'd1;
			r.i1 = (a1 > {1'b0, dim_m1}) ? dim_m1 : a1[11:0];
			r.wt = (r.i0 == r.i1) ? 8'd0 : p[15:8];
			return r;
		end
	endfunction

	// position plus step, saturating
	function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0] p,
			input logic [28:0] step);
		logic [29:0] s;
		begin
			s = {2'b0, p} + {1'b0, step};
			return (s > {2'b0, POS_MAX}) ? POS_MAX : s[27:0];
		end
	endfunction

	logic        state_q;
	logic [10:0] source_width_q, output_size_q;
	logic [12:0] source_height_q;
	logic [28:0] scale_step_q;

	logic [ROW_ADDR_W-1:0] src_col_q;
	logic [11:0]           src_row_q;
	logic [10:0]           dst_col_q, dst_row_q;
	logic [POS_W-1:0]      next_x_q, next_y_q;
	logic [7:0]            left_pixel_q, left_above_q;
	logic [7:0]            pix_q;
	logic                  req_valid_q;
	interp_req_t           req_q;

	logic        accept, req_ready;
	logic [10:0] width_eff, nout_eff, width_m1, nout_m1;
	logic [12:0] height_eff, height_m1;
	logic [27:0] half_step, start_pos;
	logic [7:0]  above;
	pos_split_t  sx, sy;
	logic        row_hit, emit, row_done, frame_done;
	logic [10:0] col_next;
	logic [12:0] row_next;
	logic [7:0]  tl, tr, bl, br;

	assign accept    = pix_valid && !pix_stall;
	assign pix_stall = !((state_q == ST_IDLE) && !req_valid_q);

	// effective configuration
	always_comb begin
		if (source_width_q == 11'd0) width_eff = 11'd1;
		else if (source_width_q > 11'(MAX_ROW_PIXELS)) width_eff = 11'(MAX_ROW_PIXELS);
		else width_eff = source_width_q;
		if (source_height_q == 13'd0) height_eff = 13'd1;
		else if (source_height_q > 13'(MAX_ROWS)) height_eff = 13'(MAX_ROWS);
		else height_eff = source_height_q;
		nout_eff  = (output_size_q > 11'(MAX_OUT_SIZE)) ? 11'(MAX_OUT_SIZE) : output_size_q;
		width_m1  = width_eff - 11'd1;
		height_m1 = height_eff - 13'd1;
		nout_m1   = nout_eff - 11'd1;
		half_step = scale_step_q[28:1];
		start_pos = (half_step >= POS_HALF) ? (half_step - POS_HALF) : '0;
	end

	// neighborhood decode for the pixel in the update cycle
	always_comb begin
		sy         = split_pos(next_y_q, height_m1[11:0]);
		sx         = split_pos(next_x_q, {1'b0, width_m1});
		row_hit    = (dst_row_q < nout_eff) && (src_row_q == sy.i1);
		emit       = row_hit && (dst_col_q < nout_eff) && ({2'b0, src_col_q} == sx.i1);
		col_next   = {1'b0, src_col_q} + 11'd1;
		row_next   = {1'b0, src_row_q} + 13'd1;
		row_done   = col_next >= width_eff;
		frame_done = row_next >= height_eff;
		br         = pix_q;
		bl         = (sx.i0 == sx.i1) ? pix_q : left_pixel_q;
		tr         = (sy.i0 == sy.i1) ? pix_q : above;
		if (sy.i0 == sy.i1) tl = bl;
		else if (sx.i0 == sx.i1) tl = above;
		else tl = left_above_q;
	end

	// line buffer: read on accept, write back in the update cycle
	bdn_line_ram u_line_ram (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (src_col_q),
		.wdata (pix_q),
		.re    (accept),
		.raddr (pix_data.frame_start ? '0 : src_col_q),
		.rdata (above)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= SOURCE_WIDTH_RST;
			source_height_q <= SOURCE_HEIGHT_RST;
			output_size_q   <= OUTPUT_SIZE_RST;
			scale_step_q    <= 29'(SCALE_STEP_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SOURCE_WIDTH:  source_width_q  <= cfg_data[10:0];
				CFG_SOURCE_HEIGHT: source_height_q <= cfg_data[12:0];
				CFG_OUTPUT_SIZE:   output_size_q   <= cfg_data[10:0];
				CFG_SCALE_STEP:    scale_step_q    <= cfg_data[28:0];
				default: ;
			endcase
		end
	end

	// sequencer and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			src_col_q    <= '0;
			src_row_q    <= '0;
			dst_col_q    <= '0;
			dst_row_q    <= '0;
			next_x_q     <= POS_RST;
			next_y_q     <= POS_RST;
			left_pixel_q <= '0;
			left_above_q <= '0;
			req_valid_q  <= 1'b0;
		end else begin
			if (req_valid_q && req_ready) begin
				req_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
						if (pix_data.frame_start) begin
							src_col_q    <= '0;
							src_row_q    <= '0;
							dst_col_q    <= '0;
							dst_row_q    <= '0;
							next_x_q     <= start_pos;
							next_y_q     <= start_pos;
							left_pixel_q <= '0;
							left_above_q <= '0;
						end
					end
				end
				ST_UPD: begin
					state_q      <= ST_IDLE;
					left_above_q <= above;
					left_pixel_q <= pix_q;
					if (emit) begin
						req_valid_q <= 1'b1;
						dst_col_q   <= dst_col_q + 11'd1;
						next_x_q    <= advance_pos(next_x_q, scale_step_q);
					end
					if (row_done) begin
						src_col_q    <= '0;
						dst_col_q    <= '0;
						next_x_q     <= start_pos;
						left_pixel_q <= '0;
						left_above_q <= '0;
						if (row_hit) begin
							dst_row_q <= dst_row_q + 11'd1;
							next_y_q  <= advance_pos(next_y_q, scale_step_q);
						end
						if (frame_done) begin
							src_row_q <= '0;
							dst_row_q <= '0;
							next_y_q  <= start_pos;
						end else begin
							src_row_q <= row_next[11:0];
						end
					end else begin
						src_col_q <= col_next[ROW_ADDR_W-1:0];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// captured pixel and pending sample operands
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= pix_data.pixel;
		end
		if ((state_q == ST_UPD) && emit) begin
			req_q.tl             <= tl;
			req_q.tr             <= tr;
			req_q.bl             <= bl;
			req_q.br             <= br;
			req_q.fx             <= sx.wt;
			req_q.fy             <= sy.wt;
			req_q.meta.out_col   <= dst_col_q[9:0];
			req_q.meta.out_row   <= dst_row_q[9:0];
			req_q.meta.frame_end <= (dst_row_q == nout_m1) && (dst_col_q == nout_m1);
		end
	end

	bdn_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid_q),
		.req       (req_q),
		.req_ready (req_ready),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_data  (smp_data)
	);

	// update cycle always hands back to idle
	a_upd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> state_q == ST_IDLE)
		else $error("update state held more than one cycle");

	// a sample request only comes out of an update cycle
	a_req_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(req_valid_q) |-> $past(state_q) == ST_UPD)
		else $error("sample request raised outside the update cycle");

	// frame start clears the row and column counters before the update
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pix_data.frame_start |=> src_row_q == '0 && dst_row_q == '0
			&& src_col_q == '0)
		else $error("frame start did not restart the counters");

	// output column counter never passes the largest output size
	a_dst_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> dst_col_q <= 11'(MAX_OUT_SIZE))
		else $error("output column counter out of range");

endmodule
